@@ hw/rtl/chorus_pkg.sv @@
// Shared types and constants of the chorus modulated delay.
// Field widths, register codes, sequencer states and sine table constants.
// No dependencies; compile first.
package chorus_pkg;

	// Register and field widths
	localparam int BASE_W  = 11;
	localparam int DEPTH_W = 10;
	localparam int STEP_W  = 32;
	localparam int CFG_W   = 32;
	localparam int PADDR_W = 4;

	// Delay in whole samples: base plus the signed offset, clamped at zero
	localparam int D_W = BASE_W + 1;

	// Signed sine value, Q1.15
	localparam int SINE_W = 16;

	// Product depth * sine
	localparam int PROD_W = SINE_W + 1 + DEPTH_W;

	// Register reset values
	localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(512);
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(128);
	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(89478);

	// Sine table generation: pi/2 in Q2.30 and the Taylor divisors (2n)(2n+1)
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int TAYLOR_TERMS = 8;
	localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_BASE  = 2'd0,
		REG_DEPTH = 2'd1,
		REG_STEP  = 2'd2
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SINE,
		ST_MUL,
		ST_REM,
		ST_READ,
		ST_WRITE,
		ST_OUT
	} state_t;

endpackage

@@ hw/rtl/chorus_if.sv @@
// Streaming channels of the chorus modulated delay: one for input samples,
// one for result samples. valid/ready handshake; depends on nothing.
interface chorus_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface chorus_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

@@ hw/rtl/chorus_modulated_delay.sv @@
// Chorus modulated delay: top level with configuration port and sequencer.
// Depends on chorus_pkg, chorus_if, chorus_lfo, chorus_mul, chorus_rem, chorus_mem.
//
// Each sample in is added to a copy read from a circular delay line of length
// base_delay + depth_samples (capped at MAX_DELAY, at least 1), delayed by
// base_delay + depth_samples * sin(phase) whole samples, and the sum is
// saturated. One sample is handled at a time: after acceptance it passes
// through the sine table read, the bit-serial multiplier (one depth bit per
// cycle), the bit-serial remainder unit (one delay bit per cycle), the
// memory read and the memory write before the next sample can be taken. A
// finished result waits in the output register while the next sample is
// accepted; the sequencer stalls only if that register is still full when
// the next result is ready. After reset the delay line is cleared, during
// which no sample is accepted; register writes are taken at any time and must
// be done while no sample is in flight. SINE_ENTRIES must be a power of two.
module chorus_modulated_delay #(
	parameter int MAX_DELAY    = 2048,
	parameter int SAMPLE_BITS  = 16,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	chorus_in_if.sink                        din,
	chorus_out_if.source                     dout,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [chorus_pkg::PADDR_W-1:0]   paddr,
	input  logic [chorus_pkg::CFG_W-1:0]     pwdata,
	output logic [chorus_pkg::CFG_W-1:0]     prdata,
	output logic                             pready
);
	import chorus_pkg::*;

	localparam int AW    = $clog2(MAX_DELAY);
	localparam int LEN_W = $clog2(MAX_DELAY + 1);
	localparam int SUM_W = BASE_W + 1;
	localparam int CW    = (LEN_W > SUM_W) ? LEN_W : SUM_W;

	// Configuration registers
	logic [BASE_W-1:0]  base_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [STEP_W-1:0]  step_q;
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	// Sequencer and datapath
	state_t                        state_q;
	state_t                        state_d;
	logic                          in_acc;
	logic                          lfo_adv;
	logic                          mul_start;
	logic                          rem_start;
	logic                          mem_rd;
	logic                          mem_wr;
	logic                          out_load;
	logic                          clearing;
	logic signed [SINE_W-1:0]      sine;
	logic                          mul_done;
	logic signed [PROD_W-1:0]      prod;
	logic                          rem_done;
	logic [LEN_W-1:0]              rem;
	logic signed [SAMPLE_BITS-1:0] rd_data;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic [LEN_W-1:0]              len_q;
	logic [AW-1:0]                 wp_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic [SUM_W-1:0]              len_sum;
	logic [LEN_W-1:0]              len_c;
	logic signed [D_W:0]           d_sum;
	logic [D_W-1:0]                delay;
	logic [LEN_W:0]                rd_t;
	logic [AW-1:0]                 rd_addr;
	logic [LEN_W-1:0]              wp_inc;
	logic [AW-1:0]                 wp_next;
	logic signed [SAMPLE_BITS:0]   y_sum;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	// APB decode; writes complete in the access cycle
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			depth_q <= DEPTH_RESET;
			step_q  <= STEP_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BASE: begin
					base_q <= pwdata[BASE_W-1:0];
				end
				REG_DEPTH: begin
					depth_q <= pwdata[DEPTH_W-1:0];
				end
				REG_STEP: begin
					step_q <= pwdata[STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_BASE:  prdata = CFG_W'(base_q);
			REG_DEPTH: prdata = CFG_W'(depth_q);
			REG_STEP:  prdata = CFG_W'(step_q);
			default:   prdata = '0;
		endcase
	end

	// Line length: cap at the memory size, never zero
	assign len_sum = SUM_W'(base_q) + SUM_W'(depth_q);
	always_comb begin
		if (CW'(len_sum) > CW'(MAX_DELAY)) begin
			len_c = LEN_W'(MAX_DELAY);
		end else if (len_sum == '0) begin
			len_c = LEN_W'(1);
		end else begin
			len_c = LEN_W'(len_sum);
		end
	end

	// Delay = base + floor(depth * sine / 2^15), clamped at zero
	assign d_sum = $signed({2'b00, base_q}) + (D_W+1)'($signed(prod[PROD_W-1:15]));
	assign delay = d_sum[D_W] ? '0 : d_sum[D_W-1:0];

	// Read index = (wp + len - (delay mod len)) mod len
	always_comb begin
		rd_t = (LEN_W+1)'(wp_q) + (LEN_W+1)'(len_q) - (LEN_W+1)'(rem);
		if (rd_t >= (LEN_W+1)'(len_q)) begin
			rd_t = rd_t - (LEN_W+1)'(len_q);
		end
	end
	assign rd_addr = rd_t[AW-1:0];

	// Write pointer wraps at the line length
	assign wp_inc  = LEN_W'(wp_q) + LEN_W'(1);
	assign wp_next = (wp_inc == len_q) ? '0 : wp_inc[AW-1:0];

	// Saturating sum of input and delayed sample
	assign y_sum = {x_q[SAMPLE_BITS-1], x_q} + {rd_data[SAMPLE_BITS-1], rd_data};
	always_comb begin
		if (y_sum[SAMPLE_BITS] != y_sum[SAMPLE_BITS-1]) begin
			y_sat = y_sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else begin
			y_sat = y_sum[SAMPLE_BITS-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (!clearing) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (din.valid) state_d = ST_SINE;
			end
			ST_SINE: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) state_d = ST_REM;
			end
			ST_REM: begin
				if (rem_done) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || dout.ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		din.ready = (state_q == ST_IDLE);
		in_acc    = (state_q == ST_IDLE) && din.valid;
		lfo_adv   = in_acc;
		mul_start = (state_q == ST_SINE);
		rem_start = (state_q == ST_MUL) && mul_done;
		mem_rd    = (state_q == ST_READ);
		mem_wr    = (state_q == ST_WRITE);
		out_load  = (state_q == ST_OUT) && (!out_valid_q || dout.ready);
	end

	// State, write pointer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (LEN_W'(wp_q) >= len_c) wp_q <= '0;
			end else if (mem_wr) begin
				wp_q <= wp_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sample payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q   <= din.sample_in;
			len_q <= len_c;
		end
		if (mem_wr) begin
			y_q <= y_sat;
		end
		if (out_load) begin
			out_data_q <= y_q;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_data_q;

	chorus_lfo #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_lfo (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step_q),
		.adv   (lfo_adv),
		.sine  (sine)
	);

	chorus_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.depth (depth_q),
		.mcand (sine),
		.done  (mul_done),
		.prod  (prod)
	);

	chorus_rem #(
		.LEN_W(LEN_W)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(delay),
		.divisor (len_q),
		.done    (rem_done),
		.rem     (rem)
	);

	chorus_mem #(
		.DEPTH      (MAX_DELAY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_wr),
		.wr_addr (wp_q),
		.wr_data (x_q),
		.clearing(clearing)
	);

endmodule

@@ hw/rtl/chorus_lfo.sv @@
// Sine LFO: 32-bit phase accumulator and quarter-wave sine table in Q1.15.
// Depends on chorus_pkg. SINE_ENTRIES must be a power of two.
module chorus_lfo #(
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [chorus_pkg::STEP_W-1:0]       step,
	input  logic                                adv,
	output logic signed [chorus_pkg::SINE_W-1:0] sine
);
	import chorus_pkg::*;

	localparam int RW = $clog2(SINE_ENTRIES);
	localparam int IW = RW + 2;
	localparam int TW = $clog2(SINE_ENTRIES + 1);

	// Taylor series in Q2.30, rounded half up to Q15 and capped
	function automatic logic [SINE_W-2:0] sine_entry(input int k);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		logic [63:0] q;
		x = (64'(k) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / TAYLOR_DIV[n-1];
			if ((n & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (64'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[SINE_W-2:0];
	endfunction

	logic [SINE_W-2:0] sine_rom [SINE_ENTRIES+1];

	// Constant quarter-wave table, entries 0 .. SINE_ENTRIES
	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		localparam logic [SINE_W-2:0] ENTRY = sine_entry(k);
		assign sine_rom[k] = ENTRY;
	end

	logic [STEP_W-1:0] phase_q;
	logic [SINE_W-2:0] rom_q;
	logic              neg_q;
	logic [IW-1:0]     idx;
	logic [1:0]        quad;
	logic [RW-1:0]     rem_idx;
	logic [TW-1:0]     addr;

	// Split the full-wave index into quadrant and position; mirror odd quadrants
	assign idx     = phase_q[STEP_W-1 -: IW];
	assign quad    = idx[IW-1 -: 2];
	assign rem_idx = idx[RW-1:0];
	assign addr    = quad[0] ? (TW'(SINE_ENTRIES) - TW'(rem_idx)) : TW'(rem_idx);

	// Advance the phase after each sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv) begin
			phase_q <= phase_q + step;
		end
	end

	// Registered table read for the current phase
	always_ff @(posedge clk) begin
		if (adv) begin
			rom_q <= sine_rom[addr];
			neg_q <= quad[1];
		end
	end

	// Negate in the lower half of the wave
	assign sine = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

endmodule

@@ hw/rtl/chorus_mul.sv @@
// Serial multiplier: unsigned depth times signed sine, one depth bit per cycle.
// Depends on chorus_pkg.
module chorus_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [chorus_pkg::DEPTH_W-1:0]       depth,
	input  logic signed [chorus_pkg::SINE_W-1:0] mcand,
	output logic                                 done,
	output logic signed [chorus_pkg::PROD_W-1:0] prod
);
	import chorus_pkg::*;

	localparam int CNT_W = $clog2(DEPTH_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [SINE_W:0] hi_q;
	logic [DEPTH_W-1:0] lo_q;
	logic signed [SINE_W:0] sum;
	logic               last;

	// Add the multiplicand when the current multiplier bit is set
	assign sum  = hi_q + (lo_q[0] ? {mcand[SINE_W-1], mcand} : '0);
	assign last = (cnt_q == CNT_W'(DEPTH_W - 1));

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift the partial product right by one bit each step
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= depth;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[DEPTH_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

@@ hw/rtl/chorus_rem.sv @@
// Serial remainder unit: restoring division of the delay by the line length,
// one dividend bit per cycle. Depends on chorus_pkg.
module chorus_rem #(
	parameter int LEN_W = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [chorus_pkg::D_W-1:0]    dividend,
	input  logic [LEN_W-1:0]              divisor,
	output logic                          done,
	output logic [LEN_W-1:0]              rem
);
	import chorus_pkg::*;

	localparam int CNT_W = $clog2(D_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   num_q;
	logic [LEN_W-1:0] r_q;
	logic [LEN_W:0]   shifted;
	logic [LEN_W:0]   diff;
	logic             last;

	// Bring in the next dividend bit and subtract the divisor if it fits
	assign shifted = {r_q, num_q[D_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign last    = (cnt_q == CNT_W'(D_W - 1));

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			num_q <= {num_q[D_W-2:0], 1'b0};
			if (shifted >= {1'b0, divisor}) begin
				r_q <= diff[LEN_W-1:0];
			end else begin
				r_q <= shifted[LEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

@@ hw/rtl/chorus_mem.sv @@
// Delay line memory: one read port and one write port,
// registered read data, clearing pass after reset. Depends on chorus_pkg.
module chorus_mem #(
	parameter int DEPTH       = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	output logic signed [SAMPLE_BITS-1:0]  rd_data,
	input  logic                           wr_en,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  logic signed [SAMPLE_BITS-1:0]  wr_data,
	output logic                           clearing
);
	import chorus_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic [AW-1:0]                 clr_q;
	logic                          clr_busy_q;

	// Sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Write zeros during the sweep, samples afterwards
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_busy_q;

endmodule

@@ hw/rtl/chorus_checker.sv @@
// Port-level checks of the chorus modulated delay, bound to the top level.
// Depends on chorus_modulated_delay and chorus_if.
module chorus_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Count samples accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("result changed while stalled");

	// Busy right after a transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken on consecutive cycles");

	// At most one sample in work besides a waiting result
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> pend_q <= 2'd1)
		else $error("too many samples in flight");

	// No result without a sample behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without accepted sample");

endmodule

bind chorus_modulated_delay chorus_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.sample_out(dout.sample_out)
);

@@ tb/sv/chorus_modulated_delay_tb.sv @@
// Self-checking testbench for chorus_modulated_delay: APB register setup,
// random sample stream with idle gaps, in-order chorus mix prediction.
// Depends on chorus_pkg, chorus_if and the chorus_modulated_delay RTL.
module chorus_modulated_delay_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chorus_pkg::*;

	localparam int LINE_MAX     = 2048;
	localparam int QUARTER_N    = 1024;
	localparam longint unsigned HALF_PI_Q2_30 = 64'd1686629713;
	localparam int RANDOM_ITEMS = 1830;
	localparam int HOLD_AT      = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;

	// Chorus mix predictor with its own delay line, pointer, phase and sine table
	class chorus_mix_checker;
		int unsigned base_delay;
		int unsigned depth;
		bit [31:0] phase_step;
		logic signed [15:0] line [LINE_MAX];
		int unsigned wr_ptr;
		bit [31:0] phase;
		int qsine [QUARTER_N + 1];
		logic signed [15:0] due_mix [$];
		int errors;
		int seen;

		function new();
			base_delay = 512;
			depth = 128;
			phase_step = 32'd89478;
			foreach (line[i])
				line[i] = '0;
			wr_ptr = 0;
			phase = '0;
			errors = 0;
			seen = 0;
			for (int k = 0; k <= QUARTER_N; k++)
				qsine[k] = sine_q15(k);
		endfunction

		// Taylor series of sin in Q2.30, rounded to Q15
		function int sine_q15(int unsigned k);
			longint unsigned x, term, q;
			longint sum;
			x = (longint'(k) * HALF_PI_Q2_30) / QUARTER_N;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			q = (longint'(sum) + 64'd16384) >> 15;
			if (q > 32767)
				q = 32767;
			return int'(q);
		endfunction

		function void set_reg(reg_idx_t idx, bit [31:0] val);
			case (idx)
				REG_BASE:  base_delay = val[10:0];
				REG_DEPTH: depth = val[9:0];
				REG_STEP:  phase_step = val;
				default: ;
			endcase
		endfunction

		function logic signed [15:0] predict_mix(logic signed [15:0] x);
			int unsigned len, d, rd, r;
			longint total;
			int s, y;
			len = base_delay + depth;
			if (len > LINE_MAX)
				len = LINE_MAX;
			if (len == 0)
				len = 1;
			if (wr_ptr >= len)
				wr_ptr = 0;
			// top 12 phase bits: quadrant and table offset
			r = phase[29:20];
			case (phase[31:30])
				2'd0: s = qsine[r];
				2'd1: s = qsine[QUARTER_N - r];
				2'd2: s = -qsine[r];
				default: s = -qsine[QUARTER_N - r];
			endcase
			total = longint'(base_delay) * 32768 + longint'(depth) * longint'(s);
			d = (total < 0) ? 0 : int'(total >>> 15);
			rd = (wr_ptr + len - (d % len)) % len;
			y = int'(x) + int'(line[rd]);
			line[wr_ptr] = x;
			wr_ptr = (wr_ptr + 1) % len;
			phase = phase + phase_step;
			if (y > 32767)
				y = 32767;
			if (y < -32768)
				y = -32768;
			return y[15:0];
		endfunction

		function void note_sample(logic signed [15:0] x);
			due_mix.push_back(predict_mix(x));
		endfunction

		function void check_mix(logic signed [15:0] got);
			logic signed [15:0] want;
			seen++;
			if (due_mix.size() == 0) begin
				$error("sample_out: expected none, actual %0d", got);
				errors++;
			end else begin
				want = due_mix.pop_front();
				if (got !== want) begin
					$error("sample_out: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return due_mix.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [CFG_W-1:0] pwdata, prdata;

	chorus_in_if #(.SAMPLE_BITS(16)) din_if ();
	chorus_out_if #(.SAMPLE_BITS(16)) dout_if ();

	chorus_modulated_delay u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din_if),
		.dout    (dout_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	chorus_mix_checker sb;
	int bad_reads;
	int cycle_count;
	bit src_steady;
	bit sink_steady;
	bit held_off;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Write a register, then read it back
	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val) begin
			$error("prdata %s: expected %0h, actual %0h", idx.name(), val, prdata);
			bad_reads++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_chorus(int unsigned b, int unsigned dp, logic [31:0] st);
		cfg_write(REG_BASE, b);
		cfg_write(REG_DEPTH, dp);
		cfg_write(REG_STEP, st);
	endtask

	// Offer one sample; return at the falling edge after its transfer
	task automatic push_sample(logic signed [15:0] s);
		int gap;
		if ($urandom_range(0, 63) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			din_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_if.valid = 1'b1;
		din_if.sample_in = s;
		do @(posedge clk); while (!din_if.ready);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted mix has come out
	task automatic drain();
		din_if.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(0, 15)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly short lines so that delayed samples are real data
	task automatic random_chorus();
		int unsigned b, dp;
		logic [31:0] st;
		case ($urandom_range(0, 7))
			0: b = $urandom_range(0, 2047);
			1: b = 2047;
			2: b = 0;
			default: b = $urandom_range(1, 48);
		endcase
		case ($urandom_range(0, 7))
			0: dp = $urandom_range(0, 1023);
			1: dp = 1023;
			2: dp = 0;
			default: dp = $urandom_range(1, 40);
		endcase
		case ($urandom_range(0, 5))
			0: st = '0;
			1: st = 32'hFFFF_FFFF;
			2: st = $urandom;
			default: st = $urandom_range(0, 32'h0400_0000);
		endcase
		set_chorus(b, dp, st);
	endtask

	// Stimulus
	initial begin
		logic signed [15:0] corners [6];
		int left, n;
		corners = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sh5555, 16'shAAAA};
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.sample_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		bad_reads = 0;
		src_steady = 1'b0;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: field extremes and alternating bits
		foreach (corners[i])
			push_sample(corners[i]);
		drain();

		// empty line, zero delay, pointer past the end, saturation both ways
		set_chorus(0, 0, 0);
		push_sample(16'sh7FFF);
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		push_sample(16'sh8000);
		push_sample(16'sh0001);
		drain();

		// deep modulation on a tiny base: negative delay clamps to zero
		set_chorus(1, 1023, 32'h4000_0000);
		repeat (6) push_sample(pick_sample());
		drain();

		// line longer than the memory, largest step
		set_chorus(2047, 1023, 32'hFFFF_FFFF);
		repeat (6) push_sample(pick_sample());
		drain();

		// random settings, each with a burst of samples
		left = RANDOM_ITEMS;
		while (left > 0) begin
			random_chorus();
			n = $urandom_range(80, 220);
			if (n > left)
				n = left;
			repeat (n) push_sample(pick_sample());
			left -= n;
			drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && bad_reads == 0 && sb.pending() == 0)
			$display("chorus_modulated_delay: match");
		else
			$display("chorus_modulated_delay: mismatch");
		$finish;
	end

	// Result side: random ready gaps, one long hold-off to back up the input
	initial begin
		int gap;
		dout_if.ready = 1'b0;
		sink_steady = 1'b0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				sink_steady = !sink_steady;
			gap = sink_steady ? 0 : $urandom_range(0, 4);
			if (!held_off && sb.seen >= HOLD_AT) begin
				held_off = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				dout_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			dout_if.ready = 1'b1;
			do @(posedge clk); while (!dout_if.valid);
			sb.check_mix(dout_if.sample_out);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("chorus_modulated_delay: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/chorus_pkg.sv
hw/rtl/chorus_if.sv
hw/rtl/chorus_lfo.sv
hw/rtl/chorus_mul.sv
hw/rtl/chorus_rem.sv
hw/rtl/chorus_mem.sv
hw/rtl/chorus_modulated_delay.sv
hw/rtl/chorus_checker.sv
tb/sv/chorus_modulated_delay_tb.sv
